[hdl/ptts_pkg.sv]
// Shared widths, codes and defaults for the periodic task tick scheduler.
package ptts_pkg;

    // Field widths of the request and result channels
    localparam int REQ_W    = 3;
    localparam int SLOT_W   = 3;
    localparam int TIME_W   = 16;
    localparam int STATUS_W = 2;

    // Default size of the task table
    localparam int DEFAULT_NUM_SLOTS = 8;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TICK    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_CREATE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SUSPEND = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RESUME  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DELETE  = 3'd4;

    // Result kinds
    localparam logic KIND_REPLY = 1'b0;
    localparam logic KIND_FIRE  = 1'b1;

    // Create status codes
    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TAKEN      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_HANDLER = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RSVD       = 2'd3;

endpackage

[hdl/ptts_ram.sv]
// Generic simple dual-port RAM with registered read data.
module ptts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                                  aclk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/periodic_task_tick_scheduler_unit.sv]
// Periodic task scheduler: task table, tick walker and create/suspend/resume/delete handling.
//
// Usage: a tick request walks the task table one slot at a time, reading each slot's period
// and countdown from the table RAM in the ST_RD state and updating it in ST_EX, so a tick
// holds off further requests for its whole walk (a read and an update state per slot, then
// a closing state that also hands over the final fire notice) and also while a fire notice
// waits on a stalled result side. Fire notices leave in slot order and the final one carries
// m_last. A create passes through a reply state and always answers with one reply (m_kind 0,
// m_last 1); suspend, resume and delete are handled in the idle state and give no result. Only
// slots reachable by the 3-bit slot field can be created. The table RAM needs no clearing
// pass after reset: a per-slot written flag makes an unwritten countdown read as zero.
module periodic_task_tick_scheduler_unit #(
    parameter int NUM_SLOTS = ptts_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [ptts_pkg::REQ_W-1:0]      s_req_type,
    input  logic [ptts_pkg::SLOT_W-1:0]     s_slot,
    input  logic [ptts_pkg::TIME_W-1:0]     s_period,
    input  logic [ptts_pkg::TIME_W-1:0]     s_first_delay,
    input  logic                            s_has_handler,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_kind,
    output logic [ptts_pkg::SLOT_W-1:0]     m_fired_slot,
    output logic [ptts_pkg::STATUS_W-1:0]   m_status,
    output logic                            m_last
);

    import ptts_pkg::*;

    localparam int IDX_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int ENTRY_W = 2 * TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RD    = 3'd1;
    localparam logic [2:0] ST_EX    = 3'd2;
    localparam logic [2:0] ST_FLUSH = 3'd3;
    localparam logic [2:0] ST_REPLY = 3'd4;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NUM_SLOTS-1:0] occ_reg, occ_next;
    logic [NUM_SLOTS-1:0] res_reg, res_next;
    logic [NUM_SLOTS-1:0] wr_reg, wr_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]     pend_slot_reg, pend_slot_next;
    logic [STATUS_W-1:0]  status_reg, status_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 m_kind_reg, m_kind_next;
    logic [SLOT_W-1:0]    m_fired_slot_reg, m_fired_slot_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic                 m_last_reg, m_last_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic                 out_free;
    logic                 out_load;
    logic                 out_kind;
    logic [SLOT_W-1:0]    out_slot;
    logic [STATUS_W-1:0]  out_status;
    logic                 out_last;

    logic                 in_range;
    logic [IDX_W-1:0]     slot_addr;
    logic [TIME_W-1:0]    ex_cnt;
    logic [TIME_W-1:0]    ex_per;
    logic [TIME_W-1:0]    ex_dec_src;
    logic [TIME_W-1:0]    ex_new_cnt;
    logic                 ex_fire;
    logic                 ex_wr;
    logic                 ex_stall;

    // Period and countdown table, one entry per slot
    ptts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_SLOTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    assign in_range  = (int'(s_slot) < NUM_SLOTS);
    assign slot_addr = IDX_W'(s_slot);

    // Per-slot update during the tick walk; one shared decrementer serves reload and count
    assign ex_cnt     = wr_reg[idx_reg] ? ram_rdata[TIME_W-1:0] : '0;
    assign ex_per     = ram_rdata[ENTRY_W-1:TIME_W];
    assign ex_dec_src = (ex_cnt == '0) ? ex_per : ex_cnt;
    assign ex_new_cnt = ex_dec_src - TIME_W'(1);
    assign ex_fire    = res_reg[idx_reg] && (ex_cnt == '0) && occ_reg[idx_reg];
    assign ex_wr      = res_reg[idx_reg] && ((ex_cnt != '0) || occ_reg[idx_reg]);
    // a second fire cannot park while the held one still waits for the output register
    assign ex_stall   = ex_fire && pend_valid_reg && !out_free;

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        occ_next        = occ_reg;
        res_next        = res_reg;
        wr_next         = wr_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = {ex_per, ex_new_cnt};
        out_load        = 1'b0;
        out_kind        = KIND_FIRE;
        out_slot        = SLOT_W'(pend_slot_reg);
        out_status      = STATUS_OK;
        out_last        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_req_type)
                        REQ_TICK: begin
                            idx_next   = '0;
                            state_next = ST_RD;
                        end
                        REQ_CREATE: begin
                            state_next = ST_REPLY;
                            if (!s_has_handler) begin
                                status_next = STATUS_NO_HANDLER;
                            end else if (!in_range || occ_reg[slot_addr]) begin
                                status_next = STATUS_TAKEN;
                            end else begin
                                status_next          = STATUS_OK;
                                occ_next[slot_addr]  = 1'b1;
                                res_next[slot_addr]  = 1'b1;
                                wr_next[slot_addr]   = 1'b1;
                                ram_we               = 1'b1;
                                ram_waddr            = slot_addr;
                                ram_wdata            = {s_period, s_first_delay};
                            end
                        end
                        REQ_SUSPEND: begin
                            if (in_range) begin
                                res_next[slot_addr] = 1'b0;
                            end
                        end
                        REQ_RESUME: begin
                            if (in_range) begin
                                res_next[slot_addr] = 1'b1;
                            end
                        end
                        REQ_DELETE: begin
                            if (in_range) begin
                                occ_next[slot_addr] = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD: begin
                state_next = ST_EX;
            end
            ST_EX: begin
                if (!ex_stall) begin
                    if (ex_wr) begin
                        ram_we           = 1'b1;
                        wr_next[idx_reg] = 1'b1;
                    end
                    // hold the newest fire back until we know whether it is the final one
                    if (ex_fire) begin
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = idx_reg;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    out_load        = 1'b1;
                    out_last        = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            ST_REPLY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_kind   = KIND_REPLY;
                    out_slot   = '0;
                    out_status = status_reg;
                    out_last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb begin
        m_valid_next      = m_valid_reg && !m_ready;
        m_kind_next       = m_kind_reg;
        m_fired_slot_next = m_fired_slot_reg;
        m_status_next     = m_status_reg;
        m_last_next       = m_last_reg;
        if (out_load) begin
            m_valid_next      = 1'b1;
            m_kind_next       = out_kind;
            m_fired_slot_next = out_slot;
            m_status_next     = out_status;
            m_last_next       = out_last;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            occ_reg        <= '0;
            res_reg        <= '0;
            wr_reg         <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            occ_reg        <= occ_next;
            res_reg        <= res_next;
            wr_reg         <= wr_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        pend_slot_reg    <= pend_slot_next;
        status_reg       <= status_next;
        m_kind_reg       <= m_kind_next;
        m_fired_slot_reg <= m_fired_slot_next;
        m_status_reg     <= m_status_next;
        m_last_reg       <= m_last_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_kind       = m_kind_reg;
    assign m_fired_slot = m_fired_slot_reg;
    assign m_status     = m_status_reg;
    assign m_last       = m_last_reg;

endmodule

[hdl/ptts_checker.sv]
// Port-level assertions for the periodic task scheduler, bound to the top level.
module ptts_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic [ptts_pkg::REQ_W-1:0]      s_req_type,
    input logic [ptts_pkg::SLOT_W-1:0]     s_slot,
    input logic [ptts_pkg::TIME_W-1:0]     s_period,
    input logic [ptts_pkg::TIME_W-1:0]     s_first_delay,
    input logic                            s_has_handler,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_kind,
    input logic [ptts_pkg::SLOT_W-1:0]     m_fired_slot,
    input logic [ptts_pkg::STATUS_W-1:0]   m_status,
    input logic                            m_last
);

    import ptts_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable({m_kind, m_fired_slot, m_status, m_last}))
        else $error("result changed while stalled");

    // A create reply is always the final result, slot field zero
    a_reply_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_REPLY) |-> m_last && (m_fired_slot == '0))
        else $error("create reply not final or slot nonzero");

    // Fire notices carry no status
    a_fire_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_FIRE) |-> (m_status == STATUS_OK))
        else $error("fire notice with nonzero status");

    // Status code three is never produced
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status != STATUS_RSVD))
        else $error("reserved status code");

    // A create transfer keeps the block busy until its reply is loaded
    a_create_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_CREATE) |=> !s_ready)
        else $error("request taken while create reply pending");

endmodule

bind periodic_task_tick_scheduler_unit ptts_checker u_ptts_checker (.*);

[verif/tb_top.sv]
// Self-checking testbench for the periodic task tick scheduler: table predictor and driver tasks.
`timescale 1ns / 100ps

import ptts_pkg::*;

// One result as seen on the m_ channel
typedef struct {
    logic                kind;
    logic [SLOT_W-1:0]   fired_slot;
    logic [STATUS_W-1:0] status;
    logic                last;
} sched_result_t;

// Shadow task table plus the queue of results it predicts
class sched_scoreboard;
    localparam int SLOTS = DEFAULT_NUM_SLOTS;
    localparam int MAX_FIRES = 8;

    bit              occupied  [SLOTS];
    bit              resumed   [SLOTS];
    bit [TIME_W-1:0] period    [SLOTS];
    bit [TIME_W-1:0] countdown [SLOTS];

    sched_result_t   due_q[$];
    int              mismatches;
    int              fires_checked;
    int              replies_checked;

    function new();
        for (int i = 0; i < SLOTS; i++) begin
            occupied[i]  = 1'b0;
            resumed[i]   = 1'b0;
            period[i]    = '0;
            countdown[i] = '0;
        end
        mismatches      = 0;
        fires_checked   = 0;
        replies_checked = 0;
    endfunction

    task report(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    function int outstanding();
        return due_q.size();
    endfunction

    // Advance the table by one accepted request and queue what it should produce
    task note_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot,
                      input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly,
                      input logic handler);
        int            fire_slots [MAX_FIRES];
        int            n;
        bit            in_range;
        sched_result_t r;
        n        = 0;
        in_range = (int'(slot) < SLOTS);
        case (req)
            REQ_TICK: begin
                // Walk slots in priority order
                for (int i = 0; i < SLOTS; i++) begin
                    if (resumed[i]) begin
                        if (countdown[i] == '0) begin
                            if (occupied[i]) begin
                                if (n < MAX_FIRES) begin
                                    fire_slots[n] = i;
                                    n++;
                                end
                                countdown[i] = period[i] - 16'd1;
                            end
                        end else begin
                            countdown[i] = countdown[i] - 16'd1;
                        end
                    end
                end
                for (int k = 0; k < n; k++) begin
                    r.kind       = KIND_FIRE;
                    r.fired_slot = fire_slots[k][SLOT_W-1:0];
                    r.status     = STATUS_OK;
                    r.last       = (k == n - 1);
                    due_q.push_back(r);
                end
            end
            REQ_CREATE: begin
                r.kind       = KIND_REPLY;
                r.fired_slot = '0;
                r.last       = 1'b1;
                if (!handler) begin
                    r.status = STATUS_NO_HANDLER;
                end else if (!in_range || occupied[slot]) begin
                    r.status = STATUS_TAKEN;
                end else begin
                    occupied[slot]  = 1'b1;
                    resumed[slot]   = 1'b1;
                    period[slot]    = per;
                    countdown[slot] = dly;
                    r.status        = STATUS_OK;
                end
                due_q.push_back(r);
            end
            REQ_SUSPEND: if (in_range) resumed[slot] = 1'b0;
            REQ_RESUME:  if (in_range) resumed[slot] = 1'b1;
            REQ_DELETE:  if (in_range) occupied[slot] = 1'b0;
            default: ;
        endcase
    endtask

    // Compare one result transfer against the oldest expectation
    task check_result(input logic kind, input logic [SLOT_W-1:0] fslot,
                      input logic [STATUS_W-1:0] status, input logic last);
        sched_result_t e;
        if (due_q.size() == 0) begin
            report($sformatf("unexpected result kind=%0d slot=%0d status=%0d last=%0d",
                             kind, fslot, status, last));
        end else begin
            e = due_q.pop_front();
            if (kind !== e.kind)
                report($sformatf("kind got %0d exp %0d", kind, e.kind));
            if (fslot !== e.fired_slot)
                report($sformatf("fired_slot got %0d exp %0d", fslot, e.fired_slot));
            if (status !== e.status)
                report($sformatf("status got %0d exp %0d", status, e.status));
            if (last !== e.last)
                report($sformatf("last got %0d exp %0d", last, e.last));
            if (e.kind == KIND_FIRE) fires_checked++;
            else replies_checked++;
        end
    endtask

    task finish_check();
        if (due_q.size() != 0)
            report($sformatf("%0d expected results never arrived", due_q.size()));
    endtask
endclass

module tb_top;

    localparam int RANDOM_ITEMS = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 2 * DEFAULT_NUM_SLOTS + 24;

    bit                  aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [SLOT_W-1:0]   s_slot;
    logic [TIME_W-1:0]   s_period;
    logic [TIME_W-1:0]   s_first_delay;
    logic                s_has_handler;
    logic                m_valid;
    logic                m_ready;
    logic                m_kind;
    logic [SLOT_W-1:0]   m_fired_slot;
    logic [STATUS_W-1:0] m_status;
    logic                m_last;

    sched_scoreboard sb = new();

    int  requests_sent = 0;
    int  ignored_sent  = 0;
    bit  hold_armed    = 1'b0;
    bit  hold_done     = 1'b0;
    bit  sender_burst  = 1'b0;

    periodic_task_tick_scheduler_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_slot        (s_slot),
        .s_period      (s_period),
        .s_first_delay (s_first_delay),
        .s_has_handler (s_has_handler),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_fired_slot  (m_fired_slot),
        .m_status      (m_status),
        .m_last        (m_last)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Time values: mostly small so tasks fire often, sometimes full range
    function automatic logic [TIME_W-1:0] pick_time();
        if ($urandom_range(0, 99) < 85)
            return TIME_W'($urandom_range(0, 6));
        return TIME_W'($urandom());
    endfunction

    // Offer one request, wait for its transfer, then idle for a random gap, none while bursting (entered at negedge)
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [SLOT_W-1:0] slot,
                                input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] dly,
                                input logic handler);
        int gap;
        s_req_type    = req;
        s_slot        = slot;
        s_period      = per;
        s_first_delay = dly;
        s_has_handler = handler;
        s_valid       = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(req, slot, per, dly, handler);
        @(negedge aclk);
        gap = sender_burst ? 0 : idle_len();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic send_random();
        int               r;
        logic [REQ_W-1:0] req;
        logic             handler;
        r       = $urandom_range(0, 99);
        handler = ($urandom_range(0, 9) != 0);
        if (r < 45) req = REQ_TICK;
        else if (r < 67) req = REQ_CREATE;
        else if (r < 75) req = REQ_SUSPEND;
        else if (r < 85) req = REQ_RESUME;
        else if (r < 93) req = REQ_DELETE;
        else req = REQ_W'($urandom_range(5, 7));
        if (req == REQ_CREATE)
            send_request(req, SLOT_W'($urandom()), pick_time(), pick_time(), handler);
        else
            send_request(req, SLOT_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()),
                         handler);
        if (req > REQ_DELETE) ignored_sent++;
        else requests_sent++;
    endtask

    // Result checker: sample on the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_kind, m_fired_slot, m_status, m_last);
    end

    // Receiver readiness: random stalls, quiet stretches and one long hold
    initial begin
        int gap_left;
        int quiet_left;
        int hold_left;
        gap_left   = 0;
        quiet_left = 0;
        hold_left  = 0;
        m_ready    = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_armed && !hold_done && hold_left == 0) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (quiet_left > 0) begin
                m_ready = 1'b1;
                quiet_left--;
            end else if (gap_left > 0) begin
                m_ready = 1'b0;
                gap_left--;
            end else begin
                m_ready  = 1'b1;
                gap_left = idle_len();
                if ($urandom_range(0, 29) == 0)
                    quiet_left = $urandom_range(20, 80);
            end
        end
    end

    // Stimulus and end of run
    initial begin
        int waited;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_req_type    = REQ_TICK;
        s_slot        = '0;
        s_period      = '0;
        s_first_delay = '0;
        s_has_handler = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: empty table, create outcomes, period extremes
        send_request(REQ_TICK,    3'd0, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(REQ_CREATE,  3'd0, 16'd1,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd0, 16'd5,    16'd5,    1'b1);
        send_request(REQ_CREATE,  3'd1, 16'd1,    16'd0,    1'b0);
        send_request(REQ_CREATE,  3'd7, 16'd0,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd3, 16'hFFFF, 16'hFFFF, 1'b1);
        send_request(REQ_TICK,    3'd7, 16'h0000, 16'h0000, 1'b0);
        send_request(REQ_TICK,    3'd0, 16'h0000, 16'h0000, 1'b0);
        // Suspended slot must not fire, then resumes
        send_request(REQ_SUSPEND, 3'd0, 16'd0,    16'd0,    1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        send_request(REQ_RESUME,  3'd0, 16'd0,    16'd0,    1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        // Deleted slot stays resumed; at countdown zero it holds without firing
        send_request(REQ_DELETE,  3'd0, 16'd0,    16'd0,    1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        // Resumed but never-written slot reads a zero countdown and stays idle
        send_request(REQ_RESUME,  3'd6, 16'd0,    16'd0,    1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        // Fill the table so many slots fire in one tick
        send_request(REQ_CREATE,  3'd0, 16'd2,    16'd1,    1'b1);
        send_request(REQ_CREATE,  3'd1, 16'd1,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd2, 16'd1,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd4, 16'd1,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd5, 16'd1,    16'd0,    1'b1);
        send_request(REQ_CREATE,  3'd6, 16'd1,    16'd0,    1'b1);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        send_request(REQ_TICK,    3'd0, 16'd0,    16'd0,    1'b0);
        // Unused request codes
        send_request(3'd5,        3'd1, 16'h5555, 16'hAAAA, 1'b1);
        send_request(3'd6,        3'd2, 16'd0,    16'd0,    1'b0);
        send_request(3'd7,        3'd4, 16'hFFFF, 16'h0000, 1'b1);

        // Random phase; the long receiver hold starts right away
        hold_armed = 1'b1;
        while (requests_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
                sender_burst = !sender_burst;
            send_random();
        end
        s_valid = 1'b0;

        // Drain outstanding results, then allow for a tick still walking
        waited = 0;
        while (sb.outstanding() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        sb.finish_check();

        $display("Covered %0d random requests (%0d unused codes) after the directed set,",
                 requests_sent, ignored_sent);
        $display("checked %0d fire notices and %0d create replies, long hold done=%0d.",
                 sb.fires_checked, sb.replies_checked, hold_done);
        if (sb.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Watchdog expired with %0d results outstanding", sb.outstanding());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[periodic_task_tick_scheduler_unit.f]
hdl/ptts_pkg.sv
hdl/ptts_ram.sv
hdl/periodic_task_tick_scheduler_unit.sv
hdl/ptts_checker.sv
verif/tb_top.sv
